// ===== rtl/jrb_pkg.sv =====
// Shared request codes, register indexes and valid-bit control type for the jitter buffer.
package jrb_pkg;

   localparam logic [2:0] REQ_ENQUEUE = 3'd0;
   localparam logic [2:0] REQ_CONSUME = 3'd1;
   localparam logic [2:0] REQ_PEEK    = 3'd2;
   localparam logic [2:0] REQ_MARK    = 3'd3;
   localparam logic [2:0] REQ_RESET   = 3'd4;

   localparam logic CSR_LEAD_LIMIT = 1'b0;
   localparam logic CSR_GAP_LIMIT  = 1'b1;

   localparam logic [7:0] LEAD_LIMIT_RESET = 8'd120;
   localparam logic [6:0] GAP_LIMIT_RESET  = 7'd8;

   localparam int SCAN_W    = 16;
   localparam int SCAN_BITS = 4;

   typedef struct packed {
      logic clear_all;
      logic set_en;
      logic purge_en;
   } vld_ctl_type;

endpackage

// ===== rtl/jrb_mem.sv =====
// Payload memory of the jitter buffer, one write port and one registered read port.
module jrb_mem #(
   parameter int WINDOW       = 128,
   parameter int PAYLOAD_BITS = 64,
   localparam int IDXW        = $clog2(WINDOW)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDXW-1:0]         wr_idx,
   input  logic [PAYLOAD_BITS-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [IDXW-1:0]         rd_idx,
   output logic [PAYLOAD_BITS-1:0] rd_data
);
   logic [PAYLOAD_BITS-1:0] mem [WINDOW];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/jrb_valid.sv =====
// Per-entry valid bits of the jitter buffer with set, clear-all and range purge.
module jrb_valid #(
   parameter int WINDOW = 128,
   localparam int IDXW  = $clog2(WINDOW)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  jrb_pkg::vld_ctl_type      ctl,
   input  logic [IDXW-1:0]           set_idx,
   input  logic [IDXW-1:0]           purge_start,
   input  logic [IDXW:0]             purge_count,
   output logic [WINDOW-1:0]         valid_vec
);
   import jrb_pkg::*;

   logic [WINDOW-1:0] valid_ff;
   logic [WINDOW-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      for (int s = 0; s < WINDOW; s++) begin
         logic [IDXW-1:0] off;
         off = IDXW'(s) - purge_start;
         if (ctl.purge_en && ({1'b0, off} < purge_count)) begin
            valid_in[s] = 1'b0;
         end
      end
      if (ctl.clear_all) begin
         valid_in = '0;
      end
      if (ctl.set_en) begin
         valid_in[set_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid_vec = valid_ff;
endmodule

// ===== rtl/tick_reorder_jitter_buffer.sv =====
// Top level of the tick reorder jitter buffer: control sequencer, base tick and registers.
// A request is taken with start while busy is low and its single response appears on
// rsp_valid for one cycle; the receiver cannot stall it. For every request but a consume
// that misses its tick once started, the payload memory is read in the cycle that ends with
// the accepting edge, the update and the response are registered as the execute state ends,
// and the cycle that shows the response can also accept the next request. A consume that
// misses scans the valid bits sixteen entries a cycle from the expected tick onward. Entries
// are placed at the tick modulo WINDOW, which must be a power of two. No clearing pass is
// needed after reset.
module tick_reorder_jitter_buffer #(
   parameter int WINDOW       = 128,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_tick,
   input  logic [63:0] req_in_payload,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [31:0] rsp_out_tick,
   output logic [63:0] rsp_out_payload,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);
   import jrb_pkg::*;

   localparam int IDXW   = $clog2(WINDOW);
   localparam int NCHUNK = WINDOW / SCAN_W;
   localparam int CHW    = $clog2(NCHUNK) + 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [2:0]              req_ff, req_in;
   logic [31:0]             tick_ff, tick_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [31:0]             base_ff, base_in;
   logic                    started_ff, started_in;
   logic [7:0]              lead_ff, lead_in;
   logic [6:0]              gap_ff, gap_in;
   logic [CHW-1:0]          chunk_ff, chunk_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [31:0]             rsp_tick_ff, rsp_tick_in;
   logic [63:0]             rsp_pay_ff, rsp_pay_in;

   vld_ctl_type             vctl;
   logic [IDXW-1:0]         set_idx, purge_start;
   logic [IDXW:0]           purge_count;
   logic [WINDOW-1:0]       valid_vec;

   logic                    mem_wr_en, mem_rd_en;
   logic [IDXW-1:0]         mem_rd_idx;
   logic [PAYLOAD_BITS-1:0] mem_rdata;

   logic [31:0]             expect_tick, eff_base, lead, lim, mark_d;
   logic [IDXW-1:0]         exp_idx, scan_base;
   logic [SCAN_W-1:0]       scan_bits;
   logic                    scan_found;
   logic [SCAN_BITS-1:0]    scan_pos;
   logic [31:0]             best;
   logic                    accept;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign expect_tick = base_ff + 32'd1;
   assign exp_idx     = expect_tick[IDXW-1:0];
   assign eff_base    = started_ff ? base_ff : (tick_ff - 32'd1);
   assign lead        = tick_ff - eff_base;
   assign lim         = (32'(lead_ff) < 32'(WINDOW)) ? 32'(lead_ff) : 32'(WINDOW);
   assign mark_d      = tick_ff - base_ff;
   assign scan_base   = exp_idx + IDXW'({chunk_ff, {SCAN_BITS{1'b0}}});
   assign best        = 32'({chunk_ff, scan_pos});

   always_comb begin
      scan_found = 1'b0;
      scan_pos   = '0;
      for (int j = 0; j < SCAN_W; j++) begin
         scan_bits[j] = valid_vec[scan_base + IDXW'(j)];
      end
      for (int j = SCAN_W - 1; j >= 0; j--) begin
         if (scan_bits[j]) begin
            scan_found = 1'b1;
            scan_pos   = SCAN_BITS'(j);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      tick_in      = tick_ff;
      pay_in       = pay_ff;
      base_in      = base_ff;
      started_in   = started_ff;
      lead_in      = lead_ff;
      gap_in       = gap_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = 1'b0;
      rsp_tick_in  = '0;
      rsp_pay_in   = '0;
      vctl         = '0;
      set_idx      = tick_ff[IDXW-1:0];
      purge_start  = exp_idx;
      purge_count  = '0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_idx   = exp_idx;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LEAD_LIMIT: lead_in = csr_write_data;
            CSR_GAP_LIMIT:  gap_in  = csr_write_data[6:0];
            default:        lead_in = lead_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_type;
               tick_in   = req_tick;
               pay_in    = req_in_payload[PAYLOAD_BITS-1:0];
               mem_rd_en = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (req_ff)
               REQ_ENQUEUE: begin
                  started_in = 1'b1;
                  base_in    = eff_base;
                  if (lead != 32'd0 && !lead[31]) begin
                     if (lead > lim) begin
                        vctl.clear_all = 1'b1;
                        base_in        = tick_ff - 32'd1;
                     end
                     vctl.set_en = 1'b1;
                     mem_wr_en   = 1'b1;
                     rsp_hit_in  = 1'b1;
                  end
               end
               REQ_CONSUME: begin
                  if (started_ff) begin
                     if (valid_vec[exp_idx]) begin
                        rsp_hit_in   = 1'b1;
                        rsp_tick_in  = expect_tick;
                        rsp_pay_in   = 64'(mem_rdata);
                        base_in      = expect_tick;
                        vctl.purge_en = 1'b1;
                        purge_count  = (IDXW+1)'(1);
                     end else begin
                        rsp_valid_in = 1'b0;
                        chunk_in     = '0;
                        state_in     = ST_SCAN;
                     end
                  end
               end
               REQ_PEEK: begin
                  if (started_ff && valid_vec[exp_idx]) begin
                     rsp_hit_in  = 1'b1;
                     rsp_tick_in = expect_tick;
                     rsp_pay_in  = 64'(mem_rdata);
                  end
               end
               REQ_MARK: begin
                  if (!started_ff) begin
                     started_in = 1'b1;
                     base_in    = tick_ff;
                  end else if (mark_d != 32'd0 && !mark_d[31]) begin
                     base_in = tick_ff;
                     if (mark_d >= 32'(WINDOW)) begin
                        vctl.clear_all = 1'b1;
                     end else begin
                        vctl.purge_en = 1'b1;
                        purge_count   = mark_d[IDXW:0];
                     end
                  end
               end
               REQ_RESET: begin
                  base_in        = '0;
                  started_in     = 1'b0;
                  vctl.clear_all = 1'b1;
               end
               default: begin
                  rsp_hit_in = 1'b0;
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_found) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (best > 32'(gap_ff)) begin
                  base_in = expect_tick + best - 32'd1;
               end
            end else if (chunk_ff == CHW'(NCHUNK - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               chunk_in = chunk_ff + CHW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         started_ff   <= 1'b0;
         lead_ff      <= LEAD_LIMIT_RESET;
         gap_ff       <= GAP_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         started_ff   <= started_in;
         lead_ff      <= lead_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      tick_ff     <= tick_in;
      pay_ff      <= pay_in;
      chunk_ff    <= chunk_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_tick_ff <= rsp_tick_in;
      rsp_pay_ff  <= rsp_pay_in;
   end

   jrb_valid #(.WINDOW(WINDOW)) u_valid (
      .clock       (clock),
      .reset       (reset),
      .ctl         (vctl),
      .set_idx     (set_idx),
      .purge_start (purge_start),
      .purge_count (purge_count),
      .valid_vec   (valid_vec)
   );

   jrb_mem #(.WINDOW(WINDOW), .PAYLOAD_BITS(PAYLOAD_BITS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_idx  (tick_ff[IDXW-1:0]),
      .wr_data (pay_ff),
      .rd_en   (mem_rd_en),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_out_tick    = rsp_tick_ff;
   assign rsp_out_payload = rsp_pay_ff;

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted transaction did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back responses");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (valid_vec == '0)) else $error("entries held before start");
endmodule
